@@ sv/apdd_pkg.sv @@
// ----------------------------------------------------------------------------
// apdd_pkg: shared definitions for the allpass delay diffuser
// Widths, limits, register indexes, controller states and the fixed-point
// helpers used by the datapath.
// ----------------------------------------------------------------------------
package apdd_pkg;

  localparam int unsigned MAX_DELAY = 4096;
  localparam int unsigned LINE_AW   = $clog2(MAX_DELAY);
  localparam int unsigned LEN_W     = $clog2(MAX_DELAY + 1);

  localparam int unsigned IN_W   = 16;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned LINE_W = 24;
  localparam int unsigned PROD_W = GAIN_W + LINE_W;
  localparam int unsigned RND_W  = PROD_W - 15;
  localparam int unsigned SUM_W  = RND_W + 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN         = CFG_IDX_W'(1);

  localparam logic signed [GAIN_W-1:0] GAIN_LIMIT = GAIN_W'(32735);

  localparam logic signed [SUM_W-1:0] LINE_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] LINE_MIN = -SUM_W'(8388608);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL1 = 4'b0010,
    S_MUL2 = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  function automatic logic signed [RND_W-1:0] rnd_q15(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] pr;
    pr = p + PROD_W'(16384);
    return pr[PROD_W-1:15];
  endfunction

  function automatic logic signed [LINE_W-1:0] sat_line(input logic signed [SUM_W-1:0] s);
    logic signed [LINE_W-1:0] r;
    if (s > LINE_MAX) begin
      r = LINE_MAX[LINE_W-1:0];
    end else if (s < LINE_MIN) begin
      r = LINE_MIN[LINE_W-1:0];
    end else begin
      r = s[LINE_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [GAIN_W-1:0] clamp_gain(input logic signed [GAIN_W-1:0] g);
    logic signed [GAIN_W-1:0] r;
    if (g > GAIN_LIMIT) begin
      r = GAIN_LIMIT;
    end else if (g < -GAIN_LIMIT) begin
      r = -GAIN_LIMIT;
    end else begin
      r = g;
    end
    return r;
  endfunction

endpackage

@@ sv/apdd_ram.sv @@
// ----------------------------------------------------------------------------
// apdd_ram: generic single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; a read of the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
module apdd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/allpass_delay_diffuser_top.sv @@
// ----------------------------------------------------------------------------
// allpass_delay_diffuser_top: Schroeder allpass over a circular delay line
// Signed Q1.15 samples in, saturated signed Q9.15 samples out.
// ----------------------------------------------------------------------------
// With a non-zero delay length a sample passes through S_MUL1, S_MUL2 and
// S_FIN to the output register, and the next sample is taken only back in
// S_IDLE, so no sample is accepted before the last one is through. The line
// RAM is read at the input transfer, the two multiplier steps are each
// registered, and the final subtract and saturate loads the output
// register. A stalled output holds the block in that last step.
// With a delay length of zero the sample is passed straight to the output
// register, one per cycle while the output is free. The line is never swept
// clear: a fill count records how far the line has been written since the
// last length write, and entries beyond it read as zero, so the block is
// ready directly after reset and after every length write. Gain is clamped
// to +-0.999 when written, and the length is limited to the line depth.
module allpass_delay_diffuser_top
  import apdd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [IN_W-1:0]       sample_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [LINE_W-1:0]     sample_out_o
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]          len_q;
  logic [LEN_W-1:0]          fill_q, fill_d;
  logic [LINE_AW-1:0]        pos_q, pos_d;
  logic signed [GAIN_W-1:0]  gain_q;
  logic signed [IN_W-1:0]    x_q;
  logic signed [LINE_W-1:0]  d_q;
  logic                      dval_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic                      out_valid_q;
  logic signed [LINE_W-1:0]  out_data_q;

  logic                      in_xfer, out_free, out_load;
  logic signed [LINE_W-1:0]  out_data_d;
  logic signed [LINE_W-1:0]  rdata, d_val, v_val, y_val;
  logic [LEN_W-1:0]          len_wr, pos_inc;
  logic                      ram_we, ram_re;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && ((len_q != '0) || out_free));
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign ram_re     = in_xfer && (len_q != '0);
  assign ram_we     = (state_q == S_MUL2);

  assign len_wr = (cfg_wdata_i[LEN_W-1:0] > LEN_W'(MAX_DELAY)) ? LEN_W'(MAX_DELAY)
                                                               : cfg_wdata_i[LEN_W-1:0];

  apdd_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_DELAY)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (v_val),
    .re_i    (ram_re),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  assign d_val   = dval_q ? rdata : '0;
  assign v_val   = sat_line(SUM_W'(x_q) + SUM_W'(rnd_q15(prod_q)));
  assign y_val   = sat_line(SUM_W'(d_q) - SUM_W'(rnd_q15(prod_q)));
  assign pos_inc = LEN_W'(pos_q) + LEN_W'(1);

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    fill_d     = fill_q;
    prod_d     = prod_q;
    out_load   = 1'b0;
    out_data_d = y_val;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (len_q == '0) begin
            out_load   = 1'b1;
            out_data_d = LINE_W'(sample_in_i);
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      S_MUL1: begin
        prod_d  = gain_q * d_val;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = gain_q * v_val;
        pos_d   = (pos_inc == len_q) ? '0 : pos_inc[LINE_AW-1:0];
        if (LEN_W'(pos_q) == fill_q) begin
          fill_d = fill_q + LEN_W'(1);
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    if (cfg_we_i && (cfg_idx_i == REG_DELAY_LENGTH)) begin
      pos_d  = '0;
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_q       <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      gain_q      <= '0;
      out_valid_q <= 1'b0;
      dval_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      fill_q  <= fill_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_DELAY_LENGTH: begin
            len_q <= len_wr;
          end
          REG_GAIN: begin
            gain_q <= clamp_gain(cfg_wdata_i);
          end
          default: begin
          end
        endcase
      end
      if (ram_re) begin
        dval_q <= LEN_W'(pos_q) < fill_q;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      x_q <= sample_in_i;
    end
    if (state_q == S_MUL1) begin
      d_q <= d_val;
    end
    prod_q <= prod_d;
    if (out_load) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_data_q;

  a_fill_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_q)
    else $error("Fill count exceeds the delay length.");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LEN_W'(pos_q) < len_q) || (pos_q == '0))
    else $error("Write position lies outside the delay line.");

  a_start_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (len_q != '0) && !cfg_we_i |=> state_q == S_MUL1)
    else $error("Accepted sample did not start the line sequence.");

  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !ram_we && (state_q == S_FIN))
    else $error("Line RAM written outside the update step.");

  a_fin_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && out_free |=> out_valid_o && (state_q == S_IDLE))
    else $error("Result was not presented when the output was free.");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for allpass_delay_diffuser_top
// Samples are sent through the valid/stall input channel while a predictor
// keeps its own copy of the delay line, write position, length and gain, and
// works out each expected output sample. Results taken from the output
// channel are compared in order. The run covers passthrough, directed
// corner cases, saturation of the line and of the output, random traffic
// under several idling patterns, and a long output hold-off.
// ----------------------------------------------------------------------------
module tb;
  import apdd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = CFG_IDX_W'(3);

  localparam logic signed [IN_W-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [IN_W-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [GAIN_W-1:0] SMALL_GAIN = 16'sd64;

  localparam longint LINE_TOP    = 64'sd8388607;
  localparam longint LINE_BOTTOM = -64'sd8388608;

  localparam int SETTLE_CYCLES   = 8;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 120;
  localparam int GROWTH_ITEMS    = 310;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_idx_i;
  logic [CFG_DATA_W-1:0]    cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic signed [IN_W-1:0]   sample_in_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [LINE_W-1:0] sample_out_o;

  logic signed [LINE_W-1:0] echo_line [MAX_DELAY];
  int unsigned              echo_len;
  int unsigned              echo_pos;
  logic signed [GAIN_W-1:0] echo_gain;
  logic signed [LINE_W-1:0] pending_outputs [$];
  logic signed [LINE_W-1:0] want_out;

  int error_count = 0;
  int lost_count;
  int sender_idle_pct;
  int receiver_stall_pct;
  int hold_left;
  bit hold_taken;
  bit hold_off_request;

  allpass_delay_diffuser_top uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .sample_in_i  (sample_in_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sample_out_o (sample_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void clear_echo_line();
    for (int i = 0; i < MAX_DELAY; i++) begin
      echo_line[i] = '0;
    end
    echo_pos = 0;
  endfunction

  function automatic longint round_q15(longint g, longint v);
    return (g * v + 64'sd16384) >>> 15;
  endfunction

  function automatic longint clip_line(longint v);
    if (v > LINE_TOP) begin
      return LINE_TOP;
    end else if (v < LINE_BOTTOM) begin
      return LINE_BOTTOM;
    end
    return v;
  endfunction

  function automatic logic signed [LINE_W-1:0] diffuse_sample(logic signed [IN_W-1:0] x);
    longint      g;
    longint      d;
    longint      v;
    longint      y;
    int unsigned at;
    g = longint'(echo_gain);
    if (g > longint'(GAIN_LIMIT)) begin
      g = longint'(GAIN_LIMIT);
    end else if (g < -longint'(GAIN_LIMIT)) begin
      g = -longint'(GAIN_LIMIT);
    end
    if (echo_len == 0) begin
      y = longint'(x);
      return y[LINE_W-1:0];
    end
    at = (echo_pos < echo_len) ? echo_pos : 0;
    d = longint'(echo_line[at]);
    v = clip_line(longint'(x) + round_q15(g, d));
    echo_line[at] = v[LINE_W-1:0];
    y = clip_line(d - round_q15(g, v));
    echo_pos = (at + 1) % echo_len;
    return y[LINE_W-1:0];
  endfunction

  function automatic void mirror_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_DELAY_LENGTH: begin
        echo_len = 32'(data[LEN_W-1:0]);
        if (echo_len > MAX_DELAY) begin
          echo_len = MAX_DELAY;
        end
        clear_echo_line();
      end
      REG_GAIN: begin
        echo_gain = data;
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [IN_W-1:0] pick_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MIN;
      1: return SAMPLE_MAX;
      2: return IN_W'($urandom_range(255)) - 16'sd128;
      default: return IN_W'($urandom);
    endcase
  endfunction

  task automatic set_idle(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      IDLE_SENDER: begin
        sender_idle_pct = 82;
        receiver_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 82;
      end
      default: begin
        sender_idle_pct = 7;
        receiver_stall_pct = 7;
      end
    endcase
  endtask

  // Waits until every expected sample has been taken, then lets the design settle.
  task automatic settle();
    int waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (pending_outputs.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_outputs.size() > 0) begin
      $error("sample_out: %0d expected samples never arrived", pending_outputs.size());
      lost_count++;
      pending_outputs.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    mirror_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Leaves valid high after the transfer; the next action lowers it if needed.
  task automatic send_sample(logic signed [IN_W-1:0] s);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    pending_outputs.push_back(diffuse_sample(s));
  endtask

  task automatic test_passthrough();
    set_idle(IDLE_NONE);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd0);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    write_reg(REG_GAIN, 16'd12345);
    send_sample(16'sh5A5A);
    send_sample(16'shA5A5);
  endtask

  task automatic test_directed();
    write_reg(REG_DELAY_LENGTH, 16'd1);
    write_reg(REG_GAIN, 16'd16384);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
    send_sample(16'sd100);
    send_sample(-16'sd1);
    write_reg(REG_DELAY_LENGTH, 16'd3);
    write_reg(REG_GAIN, 16'h8000);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd1);
    send_sample(16'sd2);
    // Rewriting the same length must still clear the line.
    write_reg(REG_DELAY_LENGTH, 16'd3);
    send_sample(SAMPLE_MAX);
    send_sample(16'sd5);
    write_reg(REG_UNUSED_A, 16'hFFFF);
    write_reg(REG_UNUSED_B, 16'h0001);
    send_sample(16'sd7);
    write_reg(REG_DELAY_LENGTH, 16'h1FFF);
    write_reg(REG_GAIN, 16'h7FFF);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN);
  endtask

  // A one-entry line with gain near minus one, fed samples of alternating
  // sign, builds up until the line saturates at both ends; a small gain then
  // pushes the output past the upper 24-bit limit.
  task automatic test_saturation();
    set_idle(IDLE_BOTH);
    write_reg(REG_DELAY_LENGTH, 16'd1);
    write_reg(REG_GAIN, -GAIN_LIMIT);
    repeat (GROWTH_ITEMS / 2) begin
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
    end
    write_reg(REG_GAIN, SMALL_GAIN);
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
  endtask

  task automatic random_config();
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] gain_word;
    case ($urandom_range(9))
      0: len_word = '0;
      1: len_word = CFG_DATA_W'($urandom);
      2: len_word = CFG_DATA_W'(MAX_DELAY);
      3: len_word = CFG_DATA_W'(MAX_DELAY - 1);
      default: len_word = CFG_DATA_W'($urandom_range(12, 1));
    endcase
    case ($urandom_range(3))
      0: gain_word = $urandom_range(1) ? GAIN_LIMIT : -GAIN_LIMIT;
      1: gain_word = CFG_DATA_W'($urandom_range(4000)) - 16'd2000;
      default: gain_word = CFG_DATA_W'($urandom);
    endcase
    if ($urandom_range(3) != 0) begin
      write_reg(REG_DELAY_LENGTH, len_word);
    end
    write_reg(REG_GAIN, gain_word);
    if ($urandom_range(4) == 0) begin
      write_reg($urandom_range(1) ? REG_UNUSED_A : REG_UNUSED_B, CFG_DATA_W'($urandom));
    end
  endtask

  task automatic test_random_traffic();
    idle_mode_e mode;
    mode = IDLE_NONE;
    repeat (4) begin
      set_idle(mode);
      repeat (2) begin
        random_config();
        repeat (25) send_sample(pick_sample());
      end
      mode = mode.next();
    end
  endtask

  task automatic test_output_hold_off();
    set_idle(IDLE_NONE);
    write_reg(REG_DELAY_LENGTH, 16'd6);
    write_reg(REG_GAIN, CFG_DATA_W'($urandom));
    hold_off_request = 1'b1;
    repeat (24) send_sample(pick_sample());
  endtask

  // Output side: random stalls, or a long hold-off when one is requested.
  initial begin
    out_stall_i = 1'b0;
    hold_left   = 0;
    hold_taken  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request && !hold_taken) begin
        hold_left  = HOLD_OFF_CYCLES;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outputs.size() == 0) begin
        $error("sample_out: unexpected transfer, actual %0d", sample_out_o);
        error_count++;
      end else begin
        want_out = pending_outputs.pop_front();
        if (sample_out_o !== want_out) begin
          $error("sample_out: expected %0d, actual %0d", want_out, sample_out_o);
          error_count++;
        end
      end
    end
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = REG_DELAY_LENGTH;
    cfg_wdata_i      = '0;
    in_valid_i       = 1'b0;
    sample_in_i      = '0;
    lost_count       = 0;
    hold_off_request = 1'b0;
    echo_len         = 0;
    echo_gain        = '0;
    clear_echo_line();
    set_idle(IDLE_NONE);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_passthrough();
    test_directed();
    test_saturation();
    test_random_traffic();
    test_output_hold_off();
    settle();

    if (error_count == 0 && lost_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/apdd_pkg.sv
sv/apdd_ram.sv
sv/allpass_delay_diffuser_top.sv
dv/tb.sv
